### hw/rtl/escape_sequence_decoder_top_assert.svh
// Assertion macros shared by the escape sequence decoder RTL.
// Expects signals clk and rst in the scope of each use.
`ifndef ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH
`define ESCAPE_SEQUENCE_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ESD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define ESD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
// No dependencies; used by the interfaces and all decoder modules.
package esd_pkg;

  // Width of the internal decoded byte counter (saturating)
  localparam int LENGTH_BITS = 16;
  localparam int OUT_LENGTH_W = 16;

  // Queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Result kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Action codes
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_END  = 1'b1;

  // What follows the optional first byte of a queue entry
  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_BYTE,
    TAIL_END
  } tail_t;

  // One classified input transaction: up to two results
  typedef struct packed {
    logic        b0_en;
    logic [7:0]  b0;
    tail_t       tail;
    logic [7:0]  b1;
  } entry_t;

endpackage

### hw/rtl/esd_if.sv
// Stream interfaces for the escape sequence decoder input and output.
// Depends on esd_pkg for the length width.
interface esd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] src_byte;

  modport source (output valid, output action, output src_byte, input ready);
  modport sink (input valid, input action, input src_byte, output ready);
endinterface

interface esd_out_if;
  logic                               valid;
  logic                               ready;
  logic                               out_kind;
  logic [7:0]                         out_byte;
  logic [esd_pkg::OUT_LENGTH_W-1:0]   out_length;

  modport source (output valid, output out_kind, output out_byte, output out_length,
                  input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_length,
                output ready);
endinterface

### hw/rtl/escape_sequence_decoder_top.sv
// Escape sequence decoder: turns backslash-escaped source text into raw bytes
// (octal, hex, named and pass-through escapes). An end transaction flushes any
// pending escape and produces an end marker with the saturating decoded length.
// The decoder takes one source transaction per cycle. Each produces zero, one
// or two results; the output delivers one result per cycle unless the sink
// stalls it, so a transaction that yields two results (a digit run ended by
// another byte, or a flush plus the end marker) needs an extra output slot,
// absorbed by the 4-entry queue between the classifying front end and the
// output back end. Input stalls only when that queue is full.
// Depends on esd_pkg, esd_if, esd_front, esd_fifo and esd_back.
module escape_sequence_decoder_top (
  input  logic       clk,
  input  logic       rst,
  esd_in_if.sink     in_ch,
  esd_out_if.source  out_ch
);

  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;
  esd_pkg::entry_t push_data, pop_data;

  // Classify source transactions
  esd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue
  esd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Emit results
  esd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

### hw/rtl/esd_front.sv
// Front end: accepts source transactions, tracks escape state, classifies results.
// Depends on esd_pkg, esd_if and the assertion header.
`include "escape_sequence_decoder_top_assert.svh"

module esd_front (
  input  logic            clk,
  input  logic            rst,
  esd_in_if.sink          in_ch,
  output logic            push_valid,
  input  logic            push_ready,
  output esd_pkg::entry_t push_data
);

  typedef enum logic [1:0] {
    MODE_NORMAL,
    MODE_ESCAPE,
    MODE_OCTAL,
    MODE_HEX
  } mode_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_X         = 8'h78;

  mode_t       mode, mode_next;
  logic [1:0]  oct_left, oct_left_next;
  logic [7:0]  acc, acc_next;
  logic        accept;
  logic        is_oct;
  logic [4:0]  hex_d;
  logic [7:0]  oct_acc;
  logic [1:0]  oct_left_dec;
  esd_pkg::entry_t ent;

  // Hex digit value, bit 4 flags a valid digit
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) r = {1'b1, 4'(b - 8'h30)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    return r;
  endfunction

  // Named escape letters map to control bytes, others pass through
  function automatic logic [7:0] named_escape(input logic [7:0] b);
    logic [7:0] r;
    unique case (b)
      8'h61:   r = 8'h07;
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h73:   r = 8'h20;
      8'h74:   r = 8'h09;
      8'h76:   r = 8'h0B;
      8'h45:   r = 8'h1B;
      default: r = b;
    endcase
    return r;
  endfunction

  assign accept      = in_ch.valid && in_ch.ready;
  assign in_ch.ready = push_ready;

  assign is_oct       = (in_ch.src_byte[7:3] == 5'b00110);
  assign hex_d        = hex_digit(in_ch.src_byte);
  assign oct_acc      = {acc[4:0], in_ch.src_byte[2:0]};
  assign oct_left_dec = oct_left - 2'd1;

  // Classify the transaction and compute next escape state
  always_comb begin
    mode_next     = mode;
    oct_left_next = oct_left;
    acc_next      = acc;
    ent.b0_en     = 1'b0;
    ent.b0        = 8'h00;
    ent.tail      = esd_pkg::TAIL_NONE;
    ent.b1        = in_ch.src_byte;

    if (in_ch.action == esd_pkg::ACT_END) begin
      // flush pending escape, then the end marker
      ent.b0_en     = (mode != MODE_NORMAL);
      ent.b0        = (mode == MODE_ESCAPE) ? 8'h00 : acc;
      ent.tail      = esd_pkg::TAIL_END;
      ent.b1        = 8'h00;
      mode_next     = MODE_NORMAL;
      oct_left_next = 2'd0;
      acc_next      = 8'h00;
    end else begin
      unique case (mode)
        MODE_NORMAL: begin
          if (in_ch.src_byte == CH_BACKSLASH) begin
            mode_next = MODE_ESCAPE;
          end else begin
            ent.b0_en = 1'b1;
            ent.b0    = in_ch.src_byte;
          end
        end
        MODE_ESCAPE: begin
          if (is_oct) begin
            acc_next      = {5'd0, in_ch.src_byte[2:0]};
            oct_left_next = 2'd2;
            mode_next     = MODE_OCTAL;
          end else if (in_ch.src_byte == CH_X) begin
            acc_next  = 8'h00;
            mode_next = MODE_HEX;
          end else begin
            mode_next = MODE_NORMAL;
            ent.b0_en = 1'b1;
            ent.b0    = named_escape(in_ch.src_byte);
          end
        end
        MODE_OCTAL: begin
          if (is_oct && oct_left != 2'd0) begin
            oct_left_next = oct_left_dec;
            if (oct_left_dec == 2'd0) begin
              mode_next = MODE_NORMAL;
              ent.b0_en = 1'b1;
              ent.b0    = oct_acc;
              acc_next  = 8'h00;
            end else begin
              acc_next = oct_acc;
            end
          end else begin
            // run ended: emit its value, then handle byte as plain text
            mode_next     = MODE_NORMAL;
            oct_left_next = 2'd0;
            ent.b0_en     = 1'b1;
            ent.b0        = acc;
            acc_next      = 8'h00;
            if (in_ch.src_byte == CH_BACKSLASH) mode_next = MODE_ESCAPE;
            else ent.tail = esd_pkg::TAIL_BYTE;
          end
        end
        MODE_HEX: begin
          if (hex_d[4]) begin
            acc_next = {acc[3:0], hex_d[3:0]};
          end else begin
            mode_next = MODE_NORMAL;
            ent.b0_en = 1'b1;
            ent.b0    = acc;
            acc_next  = 8'h00;
            if (in_ch.src_byte == CH_BACKSLASH) mode_next = MODE_ESCAPE;
            else ent.tail = esd_pkg::TAIL_BYTE;
          end
        end
        default: mode_next = MODE_NORMAL;
      endcase
    end
  end

  assign push_valid = in_ch.valid && (ent.b0_en || ent.tail != esd_pkg::TAIL_NONE);
  assign push_data  = ent;

  // Escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_NORMAL;
      oct_left <= 2'd0;
      acc      <= 8'h00;
    end else if (accept) begin
      mode     <= mode_next;
      oct_left <= oct_left_next;
      acc      <= acc_next;
    end
  end

  `ESD_ASSERT_NEXT(a_end_clears, accept && in_ch.action == esd_pkg::ACT_END, mode == MODE_NORMAL && acc == 8'h00, "front state not cleared after end")
  `ESD_ASSERT_NOW(a_octal_left, mode == MODE_OCTAL, oct_left != 2'd0, "octal mode with no digits left")
  `ESD_ASSERT_NEXT(a_octal_enter, accept && in_ch.action == esd_pkg::ACT_BYTE && mode == MODE_ESCAPE && is_oct, mode == MODE_OCTAL, "octal digit after backslash did not open octal run")

endmodule

### hw/rtl/esd_fifo.sv
// Short queue of classified entries between the front and back ends.
// Depends on esd_pkg and the assertion header.
`include "escape_sequence_decoder_top_assert.svh"

module esd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  esd_pkg::entry_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output esd_pkg::entry_t pop_data
);

  localparam logic [esd_pkg::FIFO_PTR_W-1:0] PTR_LAST =
    esd_pkg::FIFO_PTR_W'(esd_pkg::FIFO_DEPTH - 1);
  localparam logic [esd_pkg::FIFO_CNT_W-1:0] CNT_FULL =
    esd_pkg::FIFO_CNT_W'(esd_pkg::FIFO_DEPTH);

  esd_pkg::entry_t                  slots [esd_pkg::FIFO_DEPTH];
  logic [esd_pkg::FIFO_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [esd_pkg::FIFO_CNT_W-1:0]   count;
  logic                             push, pop;

  assign push_ready = (count != CNT_FULL);
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  `ESD_ASSERT_NOW(a_cnt_bound, 1'b1, count <= CNT_FULL, "queue occupancy out of range")
  `ESD_ASSERT_NEXT(a_cnt_inc, push && !pop, count == $past(count) + 1'b1, "queue count missed a push")
  `ESD_ASSERT_NEXT(a_cnt_dec, pop && !push, count == $past(count) - 1'b1, "queue count missed a pop")

endmodule

### hw/rtl/esd_back.sv
// Back end: drains queue entries into output transactions and counts bytes.
// Depends on esd_pkg, esd_if and the assertion header.
`include "escape_sequence_decoder_top_assert.svh"

module esd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  esd_pkg::entry_t pop_data,
  esd_out_if.source       out_ch
);

  localparam logic [esd_pkg::LENGTH_BITS-1:0] COUNT_MAX = '1;

  logic                            out_valid;
  logic                            out_kind;
  logic [7:0]                      out_byte;
  logic [esd_pkg::OUT_LENGTH_W-1:0] out_length;
  logic                            phase;
  logic [esd_pkg::LENGTH_BITS-1:0] count;
  logic [esd_pkg::LENGTH_BITS-1:0] count_inc;
  logic                            load;
  logic                            emit_tail;

  assign load      = !out_valid || out_ch.ready;
  assign emit_tail = phase || !pop_data.b0_en;
  assign pop_ready = load && (emit_tail || pop_data.tail == esd_pkg::TAIL_NONE);
  assign count_inc = (count != COUNT_MAX) ? count + 1'b1 : count;

  assign out_ch.valid      = out_valid;
  assign out_ch.out_kind   = out_kind;
  assign out_ch.out_byte   = out_byte;
  assign out_ch.out_length = out_length;

  // Output register, entry phase and saturating byte count
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
      count     <= '0;
    end else if (load) begin
      out_valid <= pop_valid;
      if (pop_valid) begin
        if (!emit_tail) begin
          out_kind   <= esd_pkg::KIND_BYTE;
          out_byte   <= pop_data.b0;
          out_length <= '0;
          count      <= count_inc;
          phase      <= (pop_data.tail != esd_pkg::TAIL_NONE);
        end else if (pop_data.tail == esd_pkg::TAIL_BYTE) begin
          out_kind   <= esd_pkg::KIND_BYTE;
          out_byte   <= pop_data.b1;
          out_length <= '0;
          count      <= count_inc;
          phase      <= 1'b0;
        end else begin
          out_kind   <= esd_pkg::KIND_END;
          out_byte   <= 8'h00;
          out_length <= esd_pkg::OUT_LENGTH_W'(count);
          count      <= '0;
          phase      <= 1'b0;
        end
      end
    end
  end

  `ESD_ASSERT_NOW(a_phase_head, phase, pop_valid && pop_data.tail != esd_pkg::TAIL_NONE, "second half pending with no tail in queue head")
  `ESD_ASSERT_NEXT(a_end_clears, load && pop_valid && emit_tail && pop_data.tail == esd_pkg::TAIL_END, count == '0, "byte count not cleared after end marker")
  `ESD_ASSERT_NOW(a_end_byte, out_valid && out_kind == esd_pkg::KIND_END, out_byte == 8'h00, "end marker carries a byte value")

endmodule

### tb/escape_sequence_decoder_top_tb.sv
// Self-checking testbench for escape_sequence_decoder_top: directed and random escape text.
// Uses esd_pkg and the esd_in_if / esd_out_if stream interfaces.
// An internal decoder predicts every output transaction, which is checked in order.
module escape_sequence_decoder_top_tb;

  localparam int     LENGTH_BITS  = esd_pkg::LENGTH_BITS;
  localparam int     OUT_LENGTH_W = esd_pkg::OUT_LENGTH_W;
  localparam logic   KIND_BYTE    = esd_pkg::KIND_BYTE;
  localparam logic   KIND_END     = esd_pkg::KIND_END;
  localparam logic   ACT_BYTE     = esd_pkg::ACT_BYTE;
  localparam logic   ACT_END      = esd_pkg::ACT_END;

  localparam int     CLK_PERIOD     = 8;
  localparam int     CALM_TAIL      = 200;
  localparam int     RANDOM_HALF    = 700;
  localparam longint TIMEOUT_CYCLES = 6000000;
  localparam longint COUNT_MAX      = (64'd1 << LENGTH_BITS) - 1;

  // Characters the decoder reacts to
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_8      = 8'h38;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ESCAPE,
    MODE_OCTAL,
    MODE_HEX
  } dec_mode_t;

  typedef struct {
    logic       action;
    logic [7:0] src;
  } src_item_t;

  typedef struct {
    logic                    kind;
    logic [7:0]              data;
    logic [OUT_LENGTH_W-1:0] length;
  } decoded_t;

  logic clk;
  logic rst;

  esd_in_if  in_if ();
  esd_out_if out_if ();

  escape_sequence_decoder_top u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  src_item_t pending_q[$];
  decoded_t  expected_q[$];

  // Decoder state as predicted
  dec_mode_t  mode       = MODE_TEXT;
  logic [1:0] octal_left = '0;
  logic [7:0] digit_acc  = '0;
  longint     decoded_cnt = 0;

  int   mismatches = 0;
  int   n_src      = 0;
  int   n_src_end  = 0;
  int   n_out      = 0;
  int   n_markers  = 0;
  int   src_gap    = 0;
  logic calm       = 1'b0;

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------
  function automatic void reset_decoder();
    mode        = MODE_TEXT;
    octal_left  = '0;
    digit_acc   = '0;
    decoded_cnt = 0;
  endfunction

  function automatic void emit_decoded(input logic [7:0] b);
    decoded_t r;
    r.kind   = KIND_BYTE;
    r.data   = b;
    r.length = '0;
    expected_q.push_back(r);
    if (decoded_cnt < COUNT_MAX) decoded_cnt++;
  endfunction

  function automatic void take_text(input logic [7:0] b);
    if (b == CH_BSLASH) mode = MODE_ESCAPE;
    else emit_decoded(b);
  endfunction

  function automatic int hex_digit(input logic [7:0] b);
    if (b >= CH_0 && b <= CH_9) return int'(b - CH_0);
    if (b >= CH_LA && b <= CH_LF) return int'(b - CH_LA) + 10;
    if (b >= CH_UA && b <= CH_UF) return int'(b - CH_UA) + 10;
    return -1;
  endfunction

  // Letter escapes; anything else stands for itself
  function automatic logic [7:0] named_value(input logic [7:0] b);
    case (b)
      8'h61:   return 8'h07; // a: bell
      8'h62:   return 8'h08; // b: backspace
      8'h66:   return 8'h0C; // f: form feed
      8'h6E:   return 8'h0A; // n: line feed
      8'h72:   return 8'h0D; // r: carriage return
      8'h73:   return 8'h20; // s: space
      8'h74:   return 8'h09; // t: tab
      8'h76:   return 8'h0B; // v: vertical tab
      8'h45:   return 8'h1B; // E: escape
      default: return b;
    endcase
  endfunction

  function automatic void decode_step(input logic action, input logic [7:0] b);
    decoded_t r;
    int       d;
    if (action == ACT_END) begin
      // flush a pending escape, then the length marker
      if (mode == MODE_ESCAPE) emit_decoded(8'h00);
      else if (mode == MODE_OCTAL || mode == MODE_HEX) emit_decoded(digit_acc);
      r.kind   = KIND_END;
      r.data   = '0;
      r.length = decoded_cnt[OUT_LENGTH_W-1:0];
      expected_q.push_back(r);
      reset_decoder();
    end else begin
      case (mode)
        MODE_TEXT: take_text(b);
        MODE_ESCAPE: begin
          if (b >= CH_0 && b <= CH_7) begin
            digit_acc  = b - CH_0;
            octal_left = 2'd2;
            mode       = MODE_OCTAL;
          end else if (b == CH_X) begin
            digit_acc = '0;
            mode      = MODE_HEX;
          end else begin
            mode = MODE_TEXT;
            emit_decoded(named_value(b));
          end
        end
        MODE_OCTAL: begin
          if (b >= CH_0 && b <= CH_7 && octal_left != 0) begin
            digit_acc  = (digit_acc << 3) + (b - CH_0);
            octal_left = octal_left - 2'd1;
            if (octal_left == 0) begin
              mode = MODE_TEXT;
              emit_decoded(digit_acc);
              digit_acc = '0;
            end
          end else begin
            // run ends: its value first, then the byte as plain text
            mode       = MODE_TEXT;
            octal_left = '0;
            emit_decoded(digit_acc);
            digit_acc = '0;
            take_text(b);
          end
        end
        default: begin
          d = hex_digit(b);
          if (d >= 0) begin
            digit_acc = (digit_acc << 4) + 8'(d);
          end else begin
            mode = MODE_TEXT;
            emit_decoded(digit_acc);
            digit_acc = '0;
            take_text(b);
          end
        end
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void queue_src(input logic action, input logic [7:0] b);
    src_item_t it;
    it.action = action;
    it.src    = b;
    pending_q.push_back(it);
  endfunction

  function automatic void queue_end();
    queue_src(ACT_END, 8'($urandom));
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] rand_named();
    case ($urandom_range(0, 8))
      0:       return 8'h61;
      1:       return 8'h62;
      2:       return 8'h66;
      3:       return 8'h6E;
      4:       return 8'h72;
      5:       return 8'h73;
      6:       return 8'h74;
      7:       return 8'h76;
      default: return 8'h45;
    endcase
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int d;
    d = $urandom_range(0, 21);
    if (d < 10) return CH_0 + 8'(d);
    if (d < 16) return CH_LA + 8'(d - 10);
    return CH_UA + 8'(d - 16);
  endfunction

  // One string of escape fragments (or noise) closed by an end transaction
  function automatic void queue_random_string();
    int n_frag;
    int n_dig;
    n_frag = $urandom_range(0, 24);
    if ($urandom_range(0, 9) == 0) begin
      for (int i = 0; i < n_frag; i++)
        queue_src(ACT_BYTE, ($urandom_range(0, 3) == 0) ? CH_BSLASH : 8'($urandom));
    end else begin
      for (int i = 0; i < n_frag; i++) begin
        case ($urandom_range(0, 9))
          0, 1: queue_src(ACT_BYTE, rand_plain());
          2: begin
            queue_src(ACT_BYTE, CH_BSLASH);
            queue_src(ACT_BYTE, rand_named());
          end
          3: begin
            queue_src(ACT_BYTE, CH_BSLASH);
            n_dig = $urandom_range(1, 3);
            for (int k = 0; k < n_dig; k++) queue_src(ACT_BYTE, CH_0 + 8'($urandom_range(0, 7)));
            if ($urandom_range(0, 3) == 0) queue_src(ACT_BYTE, $urandom_range(0, 1) ? CH_8 : CH_9);
          end
          4: begin
            queue_src(ACT_BYTE, CH_BSLASH);
            queue_src(ACT_BYTE, CH_X);
            n_dig = $urandom_range(0, 4);
            for (int k = 0; k < n_dig; k++) queue_src(ACT_BYTE, rand_hex_char());
          end
          5: begin
            queue_src(ACT_BYTE, CH_BSLASH);
            queue_src(ACT_BYTE, 8'($urandom));
          end
          6: begin
            queue_src(ACT_BYTE, CH_BSLASH);
            queue_src(ACT_BYTE, $urandom_range(0, 1) ? CH_8 : CH_9);
          end
          7: begin
            queue_src(ACT_BYTE, CH_BSLASH);
            queue_src(ACT_BYTE, $urandom_range(0, 1) ? CH_BSLASH : 8'h00);
          end
          8: queue_src(ACT_BYTE, CH_BSLASH);
          default: queue_src(ACT_BYTE, 8'($urandom));
        endcase
      end
    end
    queue_end();
  endfunction

  function automatic void queue_random_part(input int n_items);
    int start;
    start = pending_q.size();
    while (pending_q.size() - start < n_items) queue_random_string();
  endfunction

  function automatic void queue_directed();
    // extremes of plain bytes, zero byte included
    queue_src(ACT_BYTE, 8'h41);
    queue_src(ACT_BYTE, 8'h00);
    queue_src(ACT_BYTE, 8'hFF);
    // named escapes
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_BYTE, 8'h6E);
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_BYTE, 8'h45);
    // three octal digits, then one above 255
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_BYTE, 8'h31);
    queue_src(ACT_BYTE, 8'h30);
    queue_src(ACT_BYTE, 8'h31);
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_BYTE, CH_7);
    queue_src(ACT_BYTE, CH_7);
    queue_src(ACT_BYTE, CH_7);
    // octal run ended by another byte
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_BYTE, CH_7);
    queue_src(ACT_BYTE, 8'h7A);
    // hex escape with no digits
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_BYTE, CH_X);
    queue_src(ACT_BYTE, 8'h67);
    // end inside a hex run
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_BYTE, CH_X);
    queue_src(ACT_BYTE, 8'h34);
    queue_src(ACT_END, 8'hFF);
    // digit 8 after backslash, then end after a lone backslash
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_BYTE, CH_8);
    queue_src(ACT_BYTE, CH_BSLASH);
    queue_src(ACT_END, 8'h00);
  endfunction

  // ---------------------------------------------------------------------------
  // Clock and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Source driver: pops pending transactions, inserts random gaps
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : src_drive
    src_item_t it;
    static int sent    = 0;
    static int gap_pct = 0;
    if (rst) begin
      in_if.valid <= 1'b0;
      src_gap     <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      calm <= (pending_q.size() <= CALM_TAIL);
      if (src_gap != 0) begin
        src_gap     <= src_gap - 1;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        it = pending_q.pop_front();
        in_if.valid    <= 1'b1;
        in_if.action   <= it.action;
        in_if.src_byte <= it.src;
        sent++;
        if (sent % 64 == 0) begin
          case ($urandom_range(0, 2))
            0:       gap_pct = 0;
            1:       gap_pct = 8;
            default: gap_pct = 30;
          endcase
        end
        if (pending_q.size() > CALM_TAIL && $urandom_range(0, 99) < gap_pct)
          src_gap <= $urandom_range(1, 7);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output sink: random back-pressure bursts, none near the end
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : sink_drive
    static int stall     = 0;
    static int stall_pct = 0;
    static int cycles    = 0;
    if (rst) begin
      out_if.ready <= 1'b0;
      stall = 0;
    end else begin
      cycles++;
      if (cycles % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 8;
          default: stall_pct = 30;
        endcase
      end
      if (stall != 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        stall = $urandom_range(0, 6);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Prediction on accepted input, in-order check of accepted output
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : score
    decoded_t want;
    if (rst) begin
      reset_decoder();
    end else begin
      if (in_if.valid && in_if.ready) begin
        decode_step(in_if.action, in_if.src_byte);
        n_src++;
        if (in_if.action == ACT_END) n_src_end++;
      end
      if (out_if.valid && out_if.ready) begin
        n_out++;
        if (out_if.out_kind == KIND_END) n_markers++;
        if (expected_q.size() == 0) begin
          $error("unexpected output transaction: out_kind %0d out_byte 0x%02h out_length %0d",
                 out_if.out_kind, out_if.out_byte, out_if.out_length);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (out_if.out_kind !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, out_if.out_kind);
            mismatches++;
          end
          if (out_if.out_byte !== want.data) begin
            $error("out_byte: expected 0x%02h, actual 0x%02h", want.data, out_if.out_byte);
            mismatches++;
          end
          if (out_if.out_length !== want.length) begin
            $error("out_length: expected %0d, actual %0d", want.length, out_if.out_length);
            mismatches++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int waited;
    rst             = 1'b1;
    in_if.valid     = 1'b0;
    in_if.action    = ACT_BYTE;
    in_if.src_byte  = '0;
    out_if.ready    = 1'b0;

    queue_directed();
    queue_random_part(RANDOM_HALF);
    queue_random_part(RANDOM_HALF);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // all stimulus accepted
    while (pending_q.size() != 0 || in_if.valid) @(posedge clk);
    // drain, bounded
    waited = 0;
    while (expected_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0) begin
      $error("%0d expected output transactions never arrived", expected_q.size());
      mismatches++;
    end

    $display("Covered %0d source transactions (%0d string ends) of directed and random escapes;",
             n_src, n_src_end);
    $display("checked %0d output transactions, %0d of them end markers.", n_out, n_markers);
    if (mismatches == 0) begin
      $display("escape_sequence_decoder_top: match");
    end else begin
      $display("escape_sequence_decoder_top: mismatch");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $error("timeout: run did not complete");
    $display("escape_sequence_decoder_top: mismatch");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/esd_pkg.sv
hw/rtl/esd_if.sv
hw/rtl/esd_front.sv
hw/rtl/esd_fifo.sv
hw/rtl/esd_back.sv
hw/rtl/escape_sequence_decoder_top.sv
tb/escape_sequence_decoder_top_tb.sv
